>>> rtl/trial_division_prime_test_macros.svh
// Assertion macros for the trial division prime test.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TDPT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TDPT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TDPT_ASSERT(lbl, clk, rst, prop, msg)
`define TDPT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

>>> rtl/tdpt_pkg.sv
// Shared widths and constants for the trial division prime test.
`timescale 1ns / 1ps
package tdpt_pkg;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
   localparam int SQ_WIDTH    = VALUE_WIDTH + 1;

   localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(3);
   localparam logic [VALUE_WIDTH-1:0] DIVISOR_STEP  = VALUE_WIDTH'(2);
   localparam logic [VALUE_WIDTH-1:0] SMALLEST_PRIME = VALUE_WIDTH'(2);
   localparam logic [SQ_WIDTH-1:0]    FIRST_SQUARE  = SQ_WIDTH'(9);
   localparam logic [SQ_WIDTH-1:0]    FIRST_SQ_STEP = SQ_WIDTH'(16);
   localparam logic [SQ_WIDTH-1:0]    SQ_STEP_INC   = SQ_WIDTH'(8);
endpackage

>>> rtl/tdpt_rem_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module tdpt_rem_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [tdpt_pkg::VALUE_WIDTH-1:0]   dividend,
   input  logic [tdpt_pkg::VALUE_WIDTH-1:0]   divisor,
   output logic                               done,
   output logic [tdpt_pkg::VALUE_WIDTH-1:0]   remainder
);
   import tdpt_pkg::*;

   logic                   active_ff, active_in;
   logic                   done_ff, done_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   assign trial = {rem_ff, shift_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      rem_in    = rem_ff;
      done_in   = active_ff && (cnt_ff == CNT_WIDTH'(1));
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_WIDTH'(VALUE_WIDTH);
         shift_in  = dividend;
         rem_in    = '0;
      end else if (active_ff) begin
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in   = cnt_ff - CNT_WIDTH'(1);
         rem_in   = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
         if (cnt_ff == CNT_WIDTH'(1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

>>> rtl/trial_division_prime_test.sv
// Top level of the trial division prime test.
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_candidate
//  rsp     | out       | rsp_valid/rsp_stall | rsp_tested_value, rsp_prime_flag
// A word is taken only while no test runs; a finished result waits in the output register.
// Each odd divisor is tried by one pass of the bit-serial remainder unit.
// Worst case, a 32-bit prime, runs near 32768 divisors.
// Zero, one, two and even words are settled in S_CHECK without a divide.
// Reset clears control state; rsp_stall holds the output register and keeps the FSM in S_FINISH.
`timescale 1ns / 1ps
`include "trial_division_prime_test_macros.svh"
module trial_division_prime_test (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tdpt_pkg::VALUE_WIDTH-1:0] req_candidate,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tdpt_pkg::VALUE_WIDTH-1:0] rsp_tested_value,
   output logic                             rsp_prime_flag
);
   import tdpt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CHECK  = 4'b0010,
      S_DIV    = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] v_ff, v_in;
   logic [VALUE_WIDTH-1:0] d_ff, d_in;
   logic [SQ_WIDTH-1:0]    sq_ff, sq_in;
   logic [SQ_WIDTH-1:0]    step_ff, step_in;
   logic                   prime_ff, prime_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_tested_value_ff, rsp_tested_value_in;
   logic                   rsp_prime_flag_ff, rsp_prime_flag_in;
   logic                   rem_start;
   logic                   rem_done;
   logic [VALUE_WIDTH-1:0] rem_value;
   logic                   req_accept;
   logic                   rsp_load;

   tdpt_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (v_ff),
      .divisor   (d_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      step_in   = step_ff;
      prime_in  = prime_ff;
      rem_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               v_in     = req_candidate;
               d_in     = FIRST_DIVISOR;
               sq_in    = FIRST_SQUARE;
               step_in  = FIRST_SQ_STEP;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_FINISH;
            if (v_ff < SMALLEST_PRIME) begin
               prime_in = 1'b0;
            end else if (v_ff == SMALLEST_PRIME) begin
               prime_in = 1'b1;
            end else if (!v_ff[0]) begin
               prime_in = 1'b0;
            end else if (sq_ff > {1'b0, v_ff}) begin
               prime_in = 1'b1;
            end else begin
               rem_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_done) begin
               if (rem_value == '0) begin
                  prime_in = 1'b0;
                  state_in = S_FINISH;
               end else begin
                  d_in     = d_ff + DIVISOR_STEP;
                  sq_in    = sq_ff + step_ff;
                  step_in  = step_ff + SQ_STEP_INC;
                  state_in = S_CHECK;
               end
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_tested_value_in = rsp_tested_value_ff;
      rsp_prime_flag_in   = rsp_prime_flag_ff;
      if (rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_tested_value_in = v_ff;
         rsp_prime_flag_in   = prime_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff                <= v_in;
      d_ff                <= d_in;
      sq_ff               <= sq_in;
      step_ff             <= step_in;
      prime_ff            <= prime_in;
      rsp_tested_value_ff <= rsp_tested_value_in;
      rsp_prime_flag_ff   <= rsp_prime_flag_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tested_value = rsp_tested_value_ff;
   assign rsp_prime_flag   = rsp_prime_flag_ff;

   `TDPT_ASSERT(a_accept_starts_check, clock, reset,
      req_accept |=> (state_ff == S_CHECK), "accepted word did not start a check")
   `TDPT_NEVER(a_rem_done_in_div, clock, reset,
      rem_done && (state_ff != S_DIV), "remainder finished outside a divide step")
   `TDPT_NEVER(a_even_not_prime, clock, reset,
      rsp_valid_ff && rsp_prime_flag_ff && !rsp_tested_value_ff[0] &&
      (rsp_tested_value_ff != SMALLEST_PRIME), "even word above two flagged prime")
   `TDPT_ASSERT(a_start_from_check, clock, reset,
      rem_start |-> (state_ff == S_CHECK) && v_ff[0], "divide started on an even word")
endmodule
